[rtl/bhpq_pkg.sv]
// types and constants for the heap priority queue
package bhpq_pkg;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int FIELD_W  = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_IDX  = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] payload;
        logic [INDEX_W-1:0] index;
    } in_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                top_valid;
        logic [FIELD_W-1:0]  top_key;
        logic [FIELD_W-1:0]  top_payload;
        logic [FIELD_W-1:0]  read_key;
        logic [FIELD_W-1:0]  read_payload;
    } out_beat_t;

endpackage

[rtl/bhpq_ram.sv]
// generic single port ram with registered read
module bhpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[rtl/binary_heap_priority_queue_top.sv]
// binary min-heap priority queue, top level
// one item at a time; every item ends with a read of the top entry for the result beat
// insert moves the new entry up past each parent whose key is larger
// remove drops the last entry, or moves it into the hole and sifts it down or up
// a held result beat makes the next item wait while the top read is retried
// aresetn clears the count and control; the heap ram is not cleared
module binary_heap_priority_queue_top #(
    parameter int CAPACITY     = 1024,
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bhpq_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bhpq_pkg::out_beat_t m_data
);
    import bhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int PW = (PAYLOAD_BITS > 0) ? PAYLOAD_BITS : 1;
    localparam int EW = KEY_BITS + PW;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE, S_UP_RD, S_UP_CMP, S_RM_LEAF, S_RM_PAR, S_RM_CMP,
        S_DN_RDL, S_DN_RDR, S_DN_CMP, S_WR_ITEM, S_RD_WAIT, S_RD_DATA,
        S_TOP_RD, S_TOP_DATA, S_OUT
    } state_t;

    state_t               state_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        pos_reg;
    logic [EW-1:0]        item_reg;
    logic [EW-1:0]        left_reg;
    logic [CW-1:0]        idx_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [EW-1:0]        rd_reg;
    out_beat_t            out_reg;
    logic                 m_valid_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [EW-1:0]        ram_wdata;
    logic [EW-1:0]        ram_rdata;
    logic                 load_out;

    bhpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    function automatic logic [KEY_BITS-1:0] key_of(input logic [EW-1:0] e);
        return e[EW-1 -: KEY_BITS];
    endfunction

    logic [CW:0]   lpos;
    logic [CW:0]   rpos;
    logic [CW-1:0] parent;
    logic [EW-1:0] in_entry;

    assign lpos     = {pos_reg, 1'b1};
    assign rpos     = lpos + (CW+1)'(1);
    assign parent   = (pos_reg - CW'(1)) >> 1;
    assign load_out = (state_reg == S_TOP_DATA) && (!m_valid_reg || m_ready);

    always_comb begin
        in_entry = '0;
        in_entry[EW-1 -: KEY_BITS] = KEY_BITS'(s_data.key);
        if (PAYLOAD_BITS > 0) begin
            in_entry[PW-1:0] = PW'(s_data.payload);
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = AW'(pos_reg);
        ram_wdata = item_reg;
        unique case (state_reg)
            S_UP_RD:   ram_addr = AW'(parent);
            S_UP_CMP:  begin
                if (key_of(item_reg) < key_of(ram_rdata)) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                end
            end
            S_RM_LEAF: ram_addr = AW'(count_reg);
            S_RM_PAR:  ram_addr = AW'(parent);
            S_DN_RDL:  ram_addr = AW'(lpos);
            S_DN_RDR:  ram_addr = AW'(rpos);
            S_DN_CMP:  begin
                if (key_of(item_reg) <= key_of(left_reg)) begin
                    if (rpos < (CW+1)'(count_reg) &&
                        key_of(item_reg) > key_of(ram_rdata)) begin
                        ram_we = 1'b1;
                        ram_wdata = ram_rdata;
                    end
                end else begin
                    ram_we = 1'b1;
                    if (rpos >= (CW+1)'(count_reg) ||
                        key_of(left_reg) < key_of(ram_rdata)) begin
                        ram_wdata = left_reg;
                    end else begin
                        ram_wdata = ram_rdata;
                    end
                end
            end
            S_WR_ITEM: ram_we = 1'b1;
            S_RD_WAIT: ram_addr = AW'(idx_reg);
            S_TOP_RD:  ram_addr = '0;
            default:   ram_addr = AW'(pos_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        idx_reg    <= CW'(s_data.index);
                        rd_reg     <= '0;
                        item_reg   <= in_entry;
                        unique case (kind_t'(s_data.kind))
                            KIND_INSERT: begin
                                if (count_reg >= CAP) begin
                                    status_reg <= ST_FULL;
                                    state_reg  <= S_TOP_RD;
                                end else begin
                                    status_reg <= ST_DONE;
                                    pos_reg    <= count_reg;
                                    count_reg  <= count_reg + CW'(1);
                                    state_reg  <= (count_reg == '0) ? S_WR_ITEM : S_UP_RD;
                                end
                            end
                            KIND_REMOVE: begin
                                if (XW'(s_data.index) >= XW'(count_reg)) begin
                                    status_reg <= ST_BAD_IDX;
                                    state_reg  <= S_TOP_RD;
                                end else begin
                                    status_reg <= ST_DONE;
                                    count_reg  <= count_reg - CW'(1);
                                    pos_reg    <= CW'(s_data.index);
                                    state_reg  <= (CW'(s_data.index) != count_reg - CW'(1)) ?
                                                  S_RM_LEAF : S_TOP_RD;
                                end
                            end
                            KIND_READ: begin
                                if (XW'(s_data.index) >= XW'(count_reg)) begin
                                    status_reg <= ST_BAD_IDX;
                                    state_reg  <= S_TOP_RD;
                                end else begin
                                    status_reg <= ST_DONE;
                                    state_reg  <= S_RD_WAIT;
                                end
                            end
                            default: begin
                                status_reg <= ST_DONE;
                                state_reg  <= S_TOP_RD;
                            end
                        endcase
                    end
                end
                S_UP_RD: state_reg <= S_UP_CMP;
                S_UP_CMP: begin
                    if (key_of(item_reg) < key_of(ram_rdata)) begin
                        pos_reg   <= parent;
                        state_reg <= (parent == '0) ? S_WR_ITEM : S_UP_RD;
                    end else begin
                        state_reg <= S_WR_ITEM;
                    end
                end
                S_RM_LEAF: state_reg <= S_RM_PAR;
                S_RM_PAR: begin
                    item_reg  <= ram_rdata;
                    state_reg <= (pos_reg == '0) ? S_DN_RDL : S_RM_CMP;
                end
                S_RM_CMP: begin
                    state_reg <= (key_of(item_reg) < key_of(ram_rdata)) ? S_UP_RD
                                                                        : S_DN_RDL;
                end
                S_DN_RDL: begin
                    state_reg <= (lpos < (CW+1)'(count_reg)) ? S_DN_RDR : S_WR_ITEM;
                end
                S_DN_RDR: begin
                    left_reg  <= ram_rdata;
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (key_of(item_reg) <= key_of(left_reg)) begin
                        if (rpos < (CW+1)'(count_reg) &&
                            key_of(item_reg) > key_of(ram_rdata)) begin
                            pos_reg   <= CW'(rpos);
                            state_reg <= S_DN_RDL;
                        end else begin
                            state_reg <= S_WR_ITEM;
                        end
                    end else if (rpos >= (CW+1)'(count_reg) ||
                                 key_of(left_reg) < key_of(ram_rdata)) begin
                        pos_reg   <= CW'(lpos);
                        state_reg <= S_DN_RDL;
                    end else begin
                        pos_reg   <= CW'(rpos);
                        state_reg <= S_DN_RDL;
                    end
                end
                S_WR_ITEM: state_reg <= S_TOP_RD;
                S_RD_WAIT: state_reg <= S_RD_DATA;
                S_RD_DATA: begin
                    rd_reg    <= ram_rdata;
                    state_reg <= S_TOP_RD;
                end
                S_TOP_RD: state_reg <= S_TOP_DATA;
                S_TOP_DATA: begin
                    if (load_out) begin
                        out_reg.status      <= status_reg;
                        out_reg.count       <= COUNT_W'(count_reg);
                        out_reg.top_valid   <= (count_reg != '0);
                        out_reg.top_key     <= (count_reg != '0) ?
                                               FIELD_W'(key_of(ram_rdata)) : '0;
                        out_reg.top_payload <= (count_reg != '0 && PAYLOAD_BITS > 0) ?
                                               FIELD_W'(ram_rdata[PW-1:0]) : '0;
                        out_reg.read_key    <= FIELD_W'(key_of(rd_reg));
                        out_reg.read_payload <= (PAYLOAD_BITS > 0) ?
                                               FIELD_W'(rd_reg[PW-1:0]) : '0;
                        state_reg   <= S_IDLE;
                    end else begin
                        state_reg <= S_TOP_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP)
        else $error("entry count above capacity");

    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken while busy");

    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && !(s_valid && s_ready)) |=> $stable(count_reg))
        else $error("count moved while idle");

    a_top_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.top_valid == (m_data.count != '0)))
        else $error("top_valid disagrees with count");
endmodule
